// ===== rtl/gqsg_pkg.sv =====
// ----------------------------------------------------------------------------
// gqsg_pkg
// Shared types and constants of the grid quad-strip generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gqsg_pkg;

    localparam int DIM_W   = 13;   // point_rows / point_cols width
    localparam int POS_W   = 12;   // quad row / column counter width
    localparam int INDEX_W = 24;   // point index width
    localparam int OP_W    = 3;

    localparam logic [DIM_W-1:0] DIM_MIN = 13'd2;
    localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

    // Result steps of one quad, in emission order. An item emits a
    // contiguous run of these.
    localparam logic [OP_W-1:0] OP_LEFT_TOP  = 3'd0;  // p
    localparam logic [OP_W-1:0] OP_LEFT_BOT  = 3'd1;  // p + cols
    localparam logic [OP_W-1:0] OP_RIGHT_TOP = 3'd2;  // p + 1
    localparam logic [OP_W-1:0] OP_RIGHT_BOT = 3'd3;  // p + 1 + cols
    localparam logic [OP_W-1:0] OP_END       = 3'd4;  // end-of-strip marker

    localparam logic RES_VERTEX = 1'b0;
    localparam logic RES_END    = 1'b1;

    // Work descriptor handed from the walker to the emitter.
    typedef struct packed {
        logic [INDEX_W-1:0] base;
        logic [DIM_W-1:0]   cols;
        logic [OP_W-1:0]    op_cur;
        logic [OP_W-1:0]    op_last;
    } gqsg_desc_t;

endpackage

`default_nettype wire

// ===== rtl/grid_quad_strip_generator_core.sv =====
// ----------------------------------------------------------------------------
// grid_quad_strip_generator_core
// Quad-strip index generator for a regular grid of quads.
//
// Usage:
//   The s_ channel carries one validity bit per quad, row-major. The m_
//   channel carries the results: vertex indices (m_kind = 0) and
//   end-of-strip markers (m_kind = 1); m_run_last flags the last result of
//   an input transfer. An invalid quad with no open strip gives no result.
//   Configure point_rows (index 0) and point_cols (index 1) through the
//   cfg_ write port while the block is idle; both reset to 2.
// Pipeline and throughput:
//   A quad's descriptor is registered in the walker; its first result is
//   then loaded into the result register, from which it leaves on m_.
//   One result leaves per cycle while m_ready is high; a quad gives 2
//   results when it extends a strip, up to 5 when it opens and closes
//   one. The result register is the limiting stage.
// Reset: clears the grid position, the open strip and both channels; the
//   registers return to 2.
// Stall: while m_ready is low the result register holds; a next quad is
//   taken as soon as the pending one has handed over its last result.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_quad_strip_generator_core
    import gqsg_pkg::*;
#(
    parameter int MAX_STRIP_POINTS = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_index,
    input  wire logic [DIM_W-1:0]   cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_quad_valid,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_kind,
    output logic [INDEX_W-1:0]      m_point_index,
    output logic                    m_run_last
);

    localparam logic CFG_POINT_ROWS = 1'b0;
    localparam logic CFG_POINT_COLS = 1'b1;

    logic [DIM_W-1:0] point_rows_reg;
    logic [DIM_W-1:0] point_cols_reg;
    logic             desc_valid;
    gqsg_desc_t       desc;
    logic             step_taken;

    // Configuration registers; raw values are kept, clamping happens in use.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_rows_reg <= DIM_MIN;
            point_cols_reg <= DIM_MIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_POINT_ROWS: point_rows_reg <= cfg_data;
                CFG_POINT_COLS: point_cols_reg <= cfg_data;
                default:        point_rows_reg <= point_rows_reg;
            endcase
        end
    end

    // Walk the grid and build the step run of each accepted quad.
    gqsg_walker #(
        .MAX_STRIP_POINTS (MAX_STRIP_POINTS)
    ) u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .point_rows   (point_rows_reg),
        .point_cols   (point_cols_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_quad_valid (s_quad_valid),
        .desc_valid   (desc_valid),
        .desc         (desc),
        .step_taken   (step_taken)
    );

    // Drive one result per cycle into the output register while m_ready does not hold it.
    gqsg_emitter u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .desc_valid    (desc_valid),
        .desc          (desc),
        .step_taken    (step_taken),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_point_index (m_point_index),
        .m_run_last    (m_run_last)
    );

endmodule

`default_nettype wire

// ===== rtl/gqsg_walker.sv =====
// ----------------------------------------------------------------------------
// gqsg_walker
// Grid position and strip state; turns each accepted quad into a descriptor
// of the result steps it causes and steps that descriptor as results leave.
// ----------------------------------------------------------------------------
`default_nettype none

module gqsg_walker
    import gqsg_pkg::*;
#(
    parameter int MAX_STRIP_POINTS = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [DIM_W-1:0]   point_rows,
    input  wire logic [DIM_W-1:0]   point_cols,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_quad_valid,
    output logic                    desc_valid,
    output gqsg_desc_t              desc,
    input  wire logic               step_taken
);

    localparam logic [DIM_W-1:0] STRIP_LIMIT = DIM_W'(MAX_STRIP_POINTS);

    logic [POS_W-1:0]   quad_col_reg,     quad_col_next;
    logic [POS_W-1:0]   quad_row_reg,     quad_row_next;
    logic               strip_open_reg,   strip_open_next;
    logic [DIM_W-1:0]   strip_points_reg, strip_points_next;
    logic               desc_valid_reg,   desc_valid_next;
    gqsg_desc_t         desc_reg,         desc_next;

    logic [DIM_W-1:0]   cols_c;
    logic [DIM_W-1:0]   rows_c;
    logic               row_end;
    logic               grid_end;
    logic [DIM_W-1:0]   pts_sum;
    logic               close_strip;
    logic [POS_W+DIM_W-1:0] prod;
    logic [INDEX_W-1:0] base;
    logic               accept;
    logic               desc_done;

    always_comb begin
        if (point_cols < DIM_MIN) begin
            cols_c = DIM_MIN;
        end else if (point_cols > DIM_MAX) begin
            cols_c = DIM_MAX;
        end else begin
            cols_c = point_cols;
        end
        if (point_rows < DIM_MIN) begin
            rows_c = DIM_MIN;
        end else if (point_rows > DIM_MAX) begin
            rows_c = DIM_MAX;
        end else begin
            rows_c = point_rows;
        end
    end

    assign row_end  = ({1'b0, quad_col_reg} + 13'd1) >= (cols_c - 13'd1);
    assign grid_end = ({1'b0, quad_row_reg} + 13'd1) >= (rows_c - 13'd1);

    assign pts_sum     = (strip_open_reg ? strip_points_reg : 13'd2) + 13'd2;
    assign close_strip = row_end || (pts_sum >= STRIP_LIMIT);

    assign prod = quad_row_reg * cols_c;
    assign base = prod[INDEX_W-1:0] + {{(INDEX_W-POS_W){1'b0}}, quad_col_reg};

    assign desc_done = desc_valid_reg && step_taken && (desc_reg.op_cur == desc_reg.op_last);
    assign s_ready   = !desc_valid_reg || desc_done;
    assign accept    = s_valid && s_ready;

    always_comb begin
        quad_col_next     = quad_col_reg;
        quad_row_next     = quad_row_reg;
        strip_open_next   = strip_open_reg;
        strip_points_next = strip_points_reg;
        desc_valid_next   = desc_valid_reg;
        desc_next         = desc_reg;

        // advance the step pointer as the emitter takes each result
        if (desc_valid_reg && step_taken) begin
            if (desc_done) begin
                desc_valid_next = 1'b0;
            end else begin
                desc_next.op_cur = desc_reg.op_cur + 3'd1;
            end
        end

        if (accept) begin
            if (row_end) begin
                quad_col_next = '0;
                quad_row_next = grid_end ? '0 : quad_row_reg + 12'd1;
            end else begin
                quad_col_next = quad_col_reg + 12'd1;
            end

            desc_next.base = base;
            desc_next.cols = cols_c;
            if (s_quad_valid) begin
                desc_valid_next   = 1'b1;
                desc_next.op_cur  = strip_open_reg ? OP_RIGHT_TOP : OP_LEFT_TOP;
                desc_next.op_last = close_strip ? OP_END : OP_RIGHT_BOT;
                strip_open_next   = !close_strip;
                strip_points_next = close_strip ? '0 : pts_sum;
            end else if (strip_open_reg) begin
                desc_valid_next   = 1'b1;
                desc_next.op_cur  = OP_END;
                desc_next.op_last = OP_END;
                strip_open_next   = 1'b0;
                strip_points_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_col_reg     <= '0;
            quad_row_reg     <= '0;
            strip_open_reg   <= 1'b0;
            strip_points_reg <= '0;
            desc_valid_reg   <= 1'b0;
        end else begin
            quad_col_reg     <= quad_col_next;
            quad_row_reg     <= quad_row_next;
            strip_open_reg   <= strip_open_next;
            strip_points_reg <= strip_points_next;
            desc_valid_reg   <= desc_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

endmodule

`default_nettype wire

// ===== rtl/gqsg_emitter.sv =====
// ----------------------------------------------------------------------------
// gqsg_emitter
// Result register: forms one result from the current descriptor step and
// holds it until the receiver takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module gqsg_emitter
    import gqsg_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               desc_valid,
    input  wire gqsg_desc_t         desc,
    output logic                    step_taken,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_kind,
    output logic [INDEX_W-1:0]      m_point_index,
    output logic                    m_run_last
);

    logic                m_valid_reg;
    logic                m_kind_reg,        m_kind_next;
    logic [INDEX_W-1:0]  m_point_index_reg, m_point_index_next;
    logic                m_run_last_reg,    m_run_last_next;
    logic                load;
    logic [INDEX_W-1:0]  cols_ext;

    assign load       = !m_valid_reg || m_ready;
    assign step_taken = load && desc_valid;
    assign cols_ext   = {{(INDEX_W-DIM_W){1'b0}}, desc.cols};

    always_comb begin
        m_kind_next        = RES_VERTEX;
        m_point_index_next = '0;
        unique case (desc.op_cur)
            OP_LEFT_TOP:  m_point_index_next = desc.base;
            OP_LEFT_BOT:  m_point_index_next = desc.base + cols_ext;
            OP_RIGHT_TOP: m_point_index_next = desc.base + 24'd1;
            OP_RIGHT_BOT: m_point_index_next = desc.base + cols_ext + 24'd1;
            OP_END:       m_kind_next        = RES_END;
            default:      m_kind_next        = RES_END;
        endcase
        m_run_last_next = (desc.op_cur == desc.op_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= desc_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_taken) begin
            m_kind_reg        <= m_kind_next;
            m_point_index_reg <= m_point_index_next;
            m_run_last_reg    <= m_run_last_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_point_index = m_point_index_reg;
    assign m_run_last    = m_run_last_reg;

endmodule

`default_nettype wire
